// File: hdl/mnso_pkg.sv
// constants shared by the midi note sawtooth oscillator
// note frequency table, receiver state codes, midi status codes, dac control bits
// no dependencies
package mnso_pkg;

  // built-in note table: note 21 (A0) upward, 88 entries
  localparam int unsigned TABLE_LEN   = 88;
  localparam int unsigned TABLE_IDX_W = $clog2(TABLE_LEN);
  localparam int unsigned FREQ_W      = 22;

  // sample rate divisor, 44107.5121 Hz in units matching millihertz * 2560
  localparam longint unsigned RATE_DIV = 64'd441075121;
  localparam longint unsigned RATE_MUL = 64'd2560;

  // upper nibble of the dac word
  localparam logic [3:0] DAC_CTRL = 4'h7;

  // midi status nibbles
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;

  // byte receiver states
  localparam logic [1:0] RX_IDLE     = 2'd0;
  localparam logic [1:0] RX_NOTE_ON  = 2'd1;
  localparam logic [1:0] RX_DONE     = 2'd2;
  localparam logic [1:0] RX_NOTE_OFF = 2'd3;

  typedef logic [FREQ_W-1:0] freq_t;
  typedef freq_t freq_table_t [TABLE_LEN];

  // equal tempered note frequencies in millihertz
  localparam freq_table_t FREQ_MHZ = '{
    22'd27500,   22'd29135,   22'd30868,   22'd32703,   22'd34648,   22'd36708,
    22'd38891,   22'd41203,   22'd43654,   22'd46249,   22'd48999,   22'd51913,
    22'd55000,   22'd58270,   22'd61735,   22'd65406,   22'd69296,   22'd73416,
    22'd77782,   22'd82407,   22'd87307,   22'd92499,   22'd97999,   22'd103826,
    22'd110000,  22'd116541,  22'd123471,  22'd130813,  22'd138591,  22'd146832,
    22'd155563,  22'd164814,  22'd174614,  22'd184997,  22'd195998,  22'd207652,
    22'd220000,  22'd233082,  22'd246942,  22'd261626,  22'd277183,  22'd293665,
    22'd311127,  22'd329628,  22'd349228,  22'd369994,  22'd391995,  22'd415305,
    22'd440000,  22'd466164,  22'd493883,  22'd523251,  22'd554365,  22'd587330,
    22'd622254,  22'd659255,  22'd698456,  22'd739989,  22'd783991,  22'd830609,
    22'd880000,  22'd932328,  22'd987767,  22'd1046502, 22'd1108731, 22'd1174659,
    22'd1244508, 22'd1318510, 22'd1396913, 22'd1479978, 22'd1567982, 22'd1661219,
    22'd1760000, 22'd1864655, 22'd1975533, 22'd2093005, 22'd2217461, 22'd2349318,
    22'd2489016, 22'd2637020, 22'd2793826, 22'd2959955, 22'd3135963, 22'd3322438,
    22'd3520000, 22'd3729310, 22'd3951066, 22'd4186009
  };

endpackage

// File: hdl/midi_note_sawtooth_oscillator.sv
// midi note-on/note-off parser driving a sawtooth phase accumulator
// holds the step table, receiver state, phase register and output register
// depends on mnso_pkg
//
//  channel | ports                        | beat contents
//  --------+------------------------------+---------------------------------------
//  in      | in_tvalid/in_tready          | tdata: midi_byte; tuser: cmd (1 = tick)
//  out     | out_tvalid/out_tready        | tdata: dac_word, gate; tuser: sample_valid
//
// one beat in gives one beat out, in the next cycle, from the output register
// a new beat is taken every cycle while the output register is empty or being drained
// the step lookup, phase add and limit compare all sit before the output register
// rst_n clears receiver state, note, gate, step and phase; out_tvalid drops
// a stall on out holds the result and stops in_tready until it is taken
module midi_note_sawtooth_oscillator #(
  parameter int unsigned NOTE_COUNT    = 88,
  parameter int unsigned LOWEST_NOTE   = 21,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] midi_byte
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] dac_word, [16] gate, [23:17] zero
  output logic        out_tuser   // [0] sample_valid
);

  localparam int unsigned PHASE_W = 8 + FRACTION_BITS;
  localparam int unsigned LIM     = (NOTE_COUNT < mnso_pkg::TABLE_LEN) ?
                                    NOTE_COUNT : mnso_pkg::TABLE_LEN;
  localparam logic [7:0]  LOW_NOTE_B  = 8'(LOWEST_NOTE);
  localparam logic [7:0]  NOTE_LIM_B  = 8'(LIM);
  localparam logic [PHASE_W-1:0] PHASE_LIMIT = PHASE_W'(255) << FRACTION_BITS;

  typedef logic [PHASE_W-1:0] step_t;
  typedef step_t step_table_t [mnso_pkg::TABLE_LEN];

  // phase steps rounded to nearest, worked out at elaboration
  function automatic step_table_t build_steps();
    step_table_t     t;
    longint unsigned num;
    for (int i = 0; i < mnso_pkg::TABLE_LEN; i++) begin
      num  = (64'(mnso_pkg::FREQ_MHZ[i]) * mnso_pkg::RATE_MUL) << FRACTION_BITS;
      t[i] = PHASE_W'((num + mnso_pkg::RATE_DIV / 2) / mnso_pkg::RATE_DIV);
    end
    return t;
  endfunction

  localparam step_table_t STEP_TABLE = build_steps();

  logic [1:0]         rx_state_r, rx_state_nxt;
  logic [7:0]         held_note_r, held_note_nxt;
  logic [PHASE_W-1:0] step_r, step_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               gate_r, gate_nxt;
  logic               out_valid_r;
  logic [23:0]        out_data_r, out_data_nxt;
  logic               out_user_r;

  logic               in_fire;
  logic [7:0]         note_idx;
  logic               in_table;
  logic [PHASE_W:0]   phase_sum;
  logic [7:0]         sample;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // table index for a note-on byte
  assign note_idx = in_tdata - LOW_NOTE_B;
  assign in_table = (in_tdata >= LOW_NOTE_B) && (note_idx < NOTE_LIM_B);

  // phase advance with reset at the limit
  assign phase_sum = {1'b0, phase_r} + {1'b0, step_r};
  assign sample    = (held_note_r != 8'd0) ? phase_r[FRACTION_BITS +: 8] : 8'd0;

  // next state and result for one beat
  always_comb begin
    rx_state_nxt  = rx_state_r;
    held_note_nxt = held_note_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    gate_nxt      = gate_r;
    out_data_nxt  = '0;
    if (in_tuser) begin
      phase_nxt = (phase_sum >= {1'b0, PHASE_LIMIT}) ? '0 : phase_sum[PHASE_W-1:0];
      out_data_nxt = {7'd0, gate_r, mnso_pkg::DAC_CTRL, sample, 4'd0};
    end else begin
      priority if (rx_state_r == mnso_pkg::RX_NOTE_ON) begin
        held_note_nxt = in_tdata;
        if (in_table) begin
          step_nxt = STEP_TABLE[note_idx[mnso_pkg::TABLE_IDX_W-1:0]];
        end
        gate_nxt     = 1'b1;
        rx_state_nxt = mnso_pkg::RX_DONE;
      end else if (rx_state_r == mnso_pkg::RX_NOTE_OFF) begin
        if (held_note_r == in_tdata) begin
          rx_state_nxt  = mnso_pkg::RX_IDLE;
          held_note_nxt = 8'd0;
          gate_nxt      = 1'b0;
        end else begin
          rx_state_nxt = mnso_pkg::RX_DONE;
        end
      end else if (in_tdata[7:4] == mnso_pkg::STATUS_NOTE_ON) begin
        rx_state_nxt = mnso_pkg::RX_NOTE_ON;
      end else if (in_tdata[7:4] == mnso_pkg::STATUS_NOTE_OFF) begin
        rx_state_nxt = mnso_pkg::RX_NOTE_OFF;
      end else begin
        // other bytes leave the receiver as it is
        rx_state_nxt = rx_state_r;
      end
      out_data_nxt = {7'd0, gate_nxt, 16'd0};
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_state_r  <= mnso_pkg::RX_IDLE;
      held_note_r <= 8'd0;
      step_r      <= '0;
      phase_r     <= '0;
      gate_r      <= 1'b0;
    end else if (in_fire) begin
      rx_state_r  <= rx_state_nxt;
      held_note_r <= held_note_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      gate_r      <= gate_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
      out_user_r <= in_tuser;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // a held note always has the gate up
  a_note_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (held_note_r != 8'd0) |-> gate_r)
    else $error("held note without gate");

  // phase never sits at or above the limit
  a_phase_lim: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < PHASE_LIMIT)
    else $error("phase beyond limit");

  // a tick beat comes out as a sample beat
  a_tick_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser) |=> (out_tvalid && out_tuser))
    else $error("tick did not give a sample");

  // the note byte after a note-on status raises the gate
  a_note_on: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_tuser && rx_state_r == mnso_pkg::RX_NOTE_ON) |=>
      (rx_state_r == mnso_pkg::RX_DONE && gate_r && out_tdata[16]))
    else $error("note-on byte not taken");

endmodule
